FILE: hw/rtl/irfp_pkg.sv
// shared constants and types for the imu rvc frame parser
package irfp_pkg;

  localparam logic [7:0]  SYNC_BYTE     = 8'hAA;
  localparam int          SUM_LEN       = 16;
  localparam int          COUNT_W       = 5;
  localparam logic [COUNT_W-1:0] LAST_DATA_IDX = COUNT_W'(SUM_LEN);
  localparam int          WINDOW_FRAMES = 20;
  localparam logic [15:0] YAW_WRAP      = 16'd3600;
  localparam logic [15:0] SCALE_RESET   = 16'd6554;
  localparam int          Q_DEPTH       = 2;
  localparam int          Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int          Q_CNT_W       = $clog2(Q_DEPTH + 1);

  // raw angles of one good frame
  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } frame_t;

  // queue status seen by the top-level byte ready and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hw/rtl/irfp_byte_if.sv
// byte channel: valid, ready and one received serial byte
interface irfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/irfp_result_if.sv
// result channel: valid, ready and the decoded angle word
interface irfp_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_x10;
  logic signed [15:0] pitch_x10;
  logic signed [15:0] roll_x10;
  logic signed [15:0] yaw_x100;
  logic signed [15:0] yaw_delta_sum;

  modport source (output valid, output yaw_x10, output pitch_x10, output roll_x10,
                  output yaw_x100, output yaw_delta_sum, input ready);
  modport sink   (input valid, input yaw_x10, input pitch_x10, input roll_x10,
                  input yaw_x100, input yaw_delta_sum, output ready);
endinterface

FILE: hw/rtl/irfp_front.sv
// front: sync hunt, body collection and checksum check
module irfp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output logic                push,
  output irfp_pkg::frame_t    push_frame
);
  import irfp_pkg::*;

  typedef enum logic [1:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_BODY
  } phase_t;

  phase_t             phase;
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         running_sum;
  logic [7:0]         frame_bytes [6];
  logic               is_check;

  assign is_check = (phase == PH_BODY) && (byte_count == LAST_DATA_IDX);
  assign push     = accept && is_check && (rx_byte == running_sum);

  assign push_frame.yaw   = {frame_bytes[1], frame_bytes[0]};
  assign push_frame.pitch = {frame_bytes[3], frame_bytes[2]};
  assign push_frame.roll  = {frame_bytes[5], frame_bytes[4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC1;
      byte_count  <= '0;
      running_sum <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_SYNC1: begin
          if (rx_byte == SYNC_BYTE) phase <= PH_SYNC2;
        end
        PH_SYNC2: begin
          if (rx_byte == SYNC_BYTE) begin
            phase       <= PH_BODY;
            byte_count  <= '0;
            running_sum <= '0;
          end else begin
            phase <= PH_SYNC1;
          end
        end
        PH_BODY: begin
          if (is_check) begin
            phase       <= PH_SYNC1;
            byte_count  <= '0;
            running_sum <= '0;
          end else begin
            running_sum <= running_sum + rx_byte;
            byte_count  <= byte_count + COUNT_W'(1);
          end
        end
        default: phase <= PH_SYNC1;
      endcase
    end
  end

  // angle bytes are body bytes one through six
  always_ff @(posedge clk) begin
    if (accept && phase == PH_BODY && byte_count >= COUNT_W'(1)
        && byte_count <= COUNT_W'(6)) begin
      frame_bytes[3'(byte_count - COUNT_W'(1))] <= rx_byte;
    end
  end

endmodule

FILE: hw/rtl/irfp_queue.sv
// short frame queue between front and back
module irfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  irfp_pkg::frame_t     push_frame,
  input  logic                 pop,
  output irfp_pkg::frame_t     head,
  output irfp_pkg::q_status_t  status
);
  import irfp_pkg::*;

  frame_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + Q_CNT_W'(1);
      else if (do_pop && !do_push) count <= count - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_frame;
  end

endmodule

FILE: hw/rtl/irfp_back.sv
// back: yaw window bookkeeping, shared angle scaler and output register
module irfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          scale,
  input  irfp_pkg::frame_t     head,
  input  irfp_pkg::q_status_t  q_status,
  output logic                 pop,
  irfp_result_if.source        result_out
);
  import irfp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SEND
  } state_t;

  localparam logic [COUNT_W-1:0] WIN_LIMIT = COUNT_W'(WINDOW_FRAMES);

  state_t             state;
  logic [1:0]         step;
  frame_t             cur;
  logic               yaw_zero;
  logic [COUNT_W-1:0] window_count;
  logic [15:0]        previous_yaw;
  logic [15:0]        delta_acc;
  logic [15:0]        held_raw_yaw;
  logic signed [15:0] sc_yaw;
  logic signed [15:0] sc_pitch;
  logic signed [15:0] sc_roll;

  logic               win_full;
  logic [15:0]        delta_acc_next;
  logic signed [15:0] operand;
  logic               op_neg;
  logic [15:0]        op_mag;
  logic [31:0]        product;
  logic [15:0]        scaled_mag;
  logic signed [15:0] scaled;
  logic signed [15:0] yaw_final;

  assign pop      = (state == ST_IDLE) && !q_status.empty;
  assign win_full = (window_count >= WIN_LIMIT);
  assign delta_acc_next = delta_acc + (16'(head.yaw) - previous_yaw);

  // one sign-magnitude multiply per cycle: yaw, pitch, roll
  always_comb begin
    case (step)
      2'd0:    operand = cur.yaw;
      2'd1:    operand = cur.pitch;
      default: operand = cur.roll;
    endcase
    op_neg     = operand[15];
    op_mag     = op_neg ? 16'(-operand) : 16'(operand);
    product    = op_mag * scale;
    scaled_mag = product[31:16];
    scaled     = op_neg ? signed'(16'(-scaled_mag)) : signed'(scaled_mag);
  end

  always_comb begin
    if (yaw_zero) yaw_final = '0;
    else if (sc_yaw[15]) yaw_final = signed'(16'(sc_yaw) + YAW_WRAP);
    else yaw_final = sc_yaw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      step             <= '0;
      window_count     <= '0;
      previous_yaw     <= '0;
      delta_acc        <= '0;
      held_raw_yaw     <= '0;
      result_out.valid <= 1'b0;
    end else begin
      if (state == ST_SEND && (!result_out.valid || result_out.ready)) begin
        result_out.valid <= 1'b1;
      end else if (result_out.valid && result_out.ready) begin
        result_out.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            cur   <= head;
            step  <= '0;
            state <= ST_SCALE;
            if (win_full) begin
              window_count <= '0;
              previous_yaw <= '0;
              delta_acc    <= '0;
              yaw_zero     <= 1'b1;
            end else begin
              window_count <= window_count + COUNT_W'(1);
              previous_yaw <= 16'(head.yaw);
              delta_acc    <= delta_acc_next;
              held_raw_yaw <= 16'(head.yaw);
              yaw_zero     <= 1'b0;
            end
          end
        end
        ST_SCALE: begin
          case (step)
            2'd0:    sc_yaw   <= scaled;
            2'd1:    sc_pitch <= scaled;
            default: sc_roll  <= scaled;
          endcase
          if (step == 2'd2) state <= ST_SEND;
          else step <= step + 2'd1;
        end
        ST_SEND: begin
          if (!result_out.valid || result_out.ready) begin
            result_out.yaw_x10       <= yaw_final;
            result_out.pitch_x10     <= sc_pitch;
            result_out.roll_x10      <= sc_roll;
            result_out.yaw_x100      <= signed'(held_raw_yaw);
            result_out.yaw_delta_sum <= signed'(delta_acc);
            state                    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/imu_rvc_frame_parser.sv
// top level of the imu rvc frame parser: front, frame queue, back, scale register
//
//  channel     | dir | handshake     | word
//  ------------+-----+---------------+-----------------------------------------
//  byte_in     | in  | valid/ready   | rx_byte, one serial byte
//  result_out  | out | valid/ready   | yaw_x10 pitch_x10 roll_x10 yaw_x100
//              |     |               | yaw_delta_sum
//  cfg         | in  | cfg_wr_en     | cfg_wr_data, angle scale q0.16
//
//  one byte word accepted per cycle; ready drops only while the two-entry
//  frame queue is full
//  a good frame reaches result_out after its checksum byte by way of the queue:
//  pop, the shared 16x16 scaler for yaw, pitch and roll in turn, then the output register
//  a stalled result_out holds its word; the back waits, the queue absorbs frames
//  synchronous reset clears parser, queue, window state and output valid, and
//  sets the scale to 6554
module imu_rvc_frame_parser (
  input  logic          clk,
  input  logic          rst,
  irfp_byte_if.sink     byte_in,
  irfp_result_if.source result_out,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data
);
  import irfp_pkg::*;

  // configuration
  logic [15:0] angle_scale_q16;

  // front to queue
  logic        accept;
  logic        push;
  frame_t      push_frame;

  // queue to back
  frame_t      head;
  q_status_t   q_status;
  logic        pop;

  // only take a byte when a finished frame is sure to find queue room
  assign byte_in.ready = !q_status.full;
  assign accept        = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_scale_q16 <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      angle_scale_q16 <= cfg_wr_data;
    end
  end

  irfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (byte_in.rx_byte),
    .push       (push),
    .push_frame (push_frame)
  );

  irfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // window bookkeeping happens at pop, so frames keep their order
  irfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .scale      (angle_scale_q16),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

FILE: hw/rtl/irfp_checker.sv
// port-level checks for the imu rvc frame parser, bound to the top level
module irfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_yaw_x10,
  input logic [15:0] out_yaw_delta_sum
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_yaw_x10) && $stable(out_yaw_delta_sum))
    else $error("result word changed while stalled");

  // reset leaves no result pending
  a_rst_no_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // reset empties the frame queue, so bytes are taken right away
  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("byte input not ready after reset");

endmodule

bind imu_rvc_frame_parser irfp_checker u_irfp_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (byte_in.ready),
  .out_valid         (result_out.valid),
  .out_ready         (result_out.ready),
  .out_yaw_x10       (result_out.yaw_x10),
  .out_yaw_delta_sum (result_out.yaw_delta_sum)
);
